// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that applies only while a result item is presented.
`define ASSERT_ON_OUT(label, prop, msg) \
	`ASSERT_CLK(label, out_valid |-> (prop), msg)

`endif

// ----- rtl/rvdec_pkg.sv -----
// Types, codes and helper functions for the RV32I instruction decoder.
package rvdec_pkg;

	typedef enum logic [6:0] {
		OPC_LOAD     = 7'h03,
		OPC_MISC_MEM = 7'h0f,
		OPC_OP_IMM   = 7'h13,
		OPC_AUIPC    = 7'h17,
		OPC_STORE    = 7'h23,
		OPC_OP       = 7'h33,
		OPC_LUI      = 7'h37,
		OPC_BRANCH   = 7'h63,
		OPC_JALR     = 7'h67,
		OPC_JAL      = 7'h6f,
		OPC_SYSTEM   = 7'h73
	} opcode_t;

	typedef enum logic [3:0] {
		CLS_INVALID   = 4'd0,
		CLS_LUI       = 4'd1,
		CLS_AUIPC     = 4'd2,
		CLS_JAL       = 4'd3,
		CLS_JALR      = 4'd4,
		CLS_BRANCH    = 4'd5,
		CLS_LOAD      = 4'd6,
		CLS_STORE     = 4'd7,
		CLS_ALU_IMM   = 4'd8,
		CLS_SHIFT_IMM = 4'd9,
		CLS_ALU_REG   = 4'd10,
		CLS_FENCE     = 4'd11,
		CLS_ECALL     = 4'd12,
		CLS_EBREAK    = 4'd13
	} insn_class_t;

	typedef enum logic [3:0] {
		ALU_ADD  = 4'd0,
		ALU_SUB  = 4'd1,
		ALU_SLL  = 4'd2,
		ALU_SLT  = 4'd3,
		ALU_SLTU = 4'd4,
		ALU_XOR  = 4'd5,
		ALU_SRL  = 4'd6,
		ALU_SRA  = 4'd7,
		ALU_OR   = 4'd8,
		ALU_AND  = 4'd9
	} alu_op_t;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SRL = 3'd5;
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_EBREAK = 12'h001;

	// Decoded part of one item; the raw fields travel alongside.
	typedef struct packed {
		logic               is_valid;
		insn_class_t        insn_class;
		alu_op_t            alu_operation;
		logic signed [31:0] immediate;
		logic [4:0]         dest_reg;
		logic [4:0]         src1_reg;
		logic [4:0]         src2_reg;
		logic [2:0]         func3_field;
	} dec_result_t;

	// Base ALU operation selected by funct3 (shift direction resolved elsewhere).
	function automatic alu_op_t f3_to_alu(input logic [2:0] f3);
		alu_op_t op;
		case (f3)
			3'd0: op = ALU_ADD;
			3'd1: op = ALU_SLL;
			3'd2: op = ALU_SLT;
			3'd3: op = ALU_SLTU;
			3'd4: op = ALU_XOR;
			3'd5: op = ALU_SRL;
			3'd6: op = ALU_OR;
			3'd7: op = ALU_AND;
			default: op = ALU_ADD;
		endcase
		return op;
	endfunction

endpackage

// ----- rtl/rvdec_decode.sv -----
// Combinational decode of one RV32I instruction word.
module rvdec_decode (
	input  logic [31:0]              word,
	output rvdec_pkg::dec_result_t   result
);
	import rvdec_pkg::*;

	logic [6:0]         opc;
	logic [2:0]         f3;
	logic [6:0]         f7;
	logic signed [31:0] imm_i;
	logic signed [31:0] imm_s;
	logic signed [31:0] imm_b;
	logic signed [31:0] imm_j;
	logic signed [31:0] imm_u;
	logic signed [31:0] imm_sh;
	logic               ok;
	insn_class_t        cls;
	alu_op_t            alu;
	logic signed [31:0] imm;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign f7  = word[31:25];

	assign imm_i  = {{20{word[31]}}, word[31:20]};
	assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b  = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
	assign imm_j  = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
	assign imm_u  = {word[31:12], 12'd0};
	assign imm_sh = {27'd0, word[24:20]};

	always_comb begin
		ok  = 1'b1;
		cls = CLS_INVALID;
		alu = ALU_ADD;
		imm = '0;
		case (opc)
			OPC_LUI: begin
				cls = CLS_LUI;
				imm = imm_u;
			end
			OPC_AUIPC: begin
				cls = CLS_AUIPC;
				imm = imm_u;
			end
			OPC_JAL: begin
				cls = CLS_JAL;
				imm = imm_j;
			end
			OPC_JALR: begin
				cls = CLS_JALR;
				imm = imm_i;
			end
			OPC_BRANCH: begin
				cls = CLS_BRANCH;
				imm = imm_b;
			end
			OPC_LOAD: begin
				cls = CLS_LOAD;
				imm = imm_i;
			end
			OPC_STORE: begin
				cls = CLS_STORE;
				imm = imm_s;
			end
			OPC_OP_IMM: begin
				if (f3 == F3_SLL || f3 == F3_SRL) begin
					// Immediate shifts ignore funct7 except for the arithmetic bit.
					cls = CLS_SHIFT_IMM;
					imm = imm_sh;
					if (f3 == F3_SLL)
						alu = ALU_SLL;
					else
						alu = word[30] ? ALU_SRA : ALU_SRL;
				end else begin
					cls = CLS_ALU_IMM;
					imm = imm_i;
					alu = f3_to_alu(f3);
				end
			end
			OPC_OP: begin
				cls = CLS_ALU_REG;
				if (f7 == F7_ALT && f3 == F3_ADD)
					alu = ALU_SUB;
				else if (f7 == F7_ALT && f3 == F3_SRL)
					alu = ALU_SRA;
				else if (f7 == F7_BASE)
					alu = f3_to_alu(f3);
				else
					ok = 1'b0;
			end
			OPC_MISC_MEM: begin
				cls = CLS_FENCE;
			end
			OPC_SYSTEM: begin
				ok = 1'b0;
				if (f3 == 3'd0 && word[11:7] == 5'd0 && word[19:15] == 5'd0) begin
					if (word[31:20] == SYS_ECALL) begin
						cls = CLS_ECALL;
						ok  = 1'b1;
					end else if (word[31:20] == SYS_EBREAK) begin
						cls = CLS_EBREAK;
						ok  = 1'b1;
					end
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		// Compressed-space words never match a 32-bit opcode, but check explicitly.
		if (word[1:0] != 2'b11)
			ok = 1'b0;
	end

	always_comb begin
		result.is_valid      = ok;
		result.insn_class    = ok ? cls : CLS_INVALID;
		result.alu_operation = ok ? alu : ALU_ADD;
		result.immediate     = ok ? imm : 32'sd0;
		result.dest_reg      = word[11:7];
		result.src1_reg      = word[19:15];
		result.src2_reg      = word[24:20];
		result.func3_field   = f3;
	end

endmodule

// ----- rtl/rv32i_instruction_decoder.sv -----
// Top level of the RV32I instruction decoder: input register, decode logic, result register.
// The decoder takes one item per clock while in_stall is low and returns one result item
// per item. A result reaches the outputs when its item moves from the input register into
// the result register, and is taken at an edge where out_stall is low. Each item is latched
// in the input register, decoded by a single pass of combinational logic, and held in the
// result register until taken. in_stall rises only when both registers hold items and the
// result is stalled, so a full pipeline of two items keeps flowing at one item per cycle.
// Invalid encodings are not dropped: they come out with is_valid low, class, ALU
// operation and immediate zero, and the register fields, pc and raw word still filled in.
module rv32i_instruction_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instr_word,
	input  logic [31:0]        fetch_pc,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_valid,
	output logic [3:0]         insn_class,
	output logic [3:0]         alu_operation,
	output logic signed [31:0] immediate,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic [2:0]         func3_field,
	output logic [31:0]        pc_out,
	output logic [31:0]        raw_word
);
	import rvdec_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [31:0] pc_s1;
	logic        valid_s2;
	dec_result_t res_s2;
	logic [31:0] word_s2;
	logic [31:0] pc_s2;
	dec_result_t dec_res;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= instr_word;
			pc_s1   <= fetch_pc;
		end
		if (adv_s2 && valid_s1) begin
			res_s2  <= dec_res;
			word_s2 <= word_s1;
			pc_s2   <= pc_s1;
		end
	end

	rvdec_decode u_decode (
		.word   (word_s1),
		.result (dec_res)
	);

	assign out_valid     = valid_s2;
	assign is_valid      = res_s2.is_valid;
	assign insn_class    = res_s2.insn_class;
	assign alu_operation = res_s2.alu_operation;
	assign immediate     = res_s2.immediate;
	assign dest_reg      = res_s2.dest_reg;
	assign src1_reg      = res_s2.src1_reg;
	assign src2_reg      = res_s2.src2_reg;
	assign func3_field   = res_s2.func3_field;
	assign pc_out        = pc_s2;
	assign raw_word      = word_s2;

endmodule

// ----- rtl/rvdec_checker.sv -----
// Port-level checks of the decoder's result items, bound to the top level.
`include "assert_macros.svh"

module rvdec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               is_valid,
	input logic [3:0]         insn_class,
	input logic [3:0]         alu_operation,
	input logic signed [31:0] immediate,
	input logic [4:0]         dest_reg,
	input logic [4:0]         src1_reg,
	input logic [4:0]         src2_reg,
	input logic [2:0]         func3_field,
	input logic [31:0]        raw_word
);
	import rvdec_pkg::*;

	logic decode_zero;
	logic fields_match;
	logic encoding_ok;

	assign decode_zero = insn_class == CLS_INVALID && alu_operation == ALU_ADD
		&& immediate == 32'sd0;
	assign fields_match = dest_reg == raw_word[11:7] && src1_reg == raw_word[19:15]
		&& src2_reg == raw_word[24:20] && func3_field == raw_word[14:12];
	assign encoding_ok = raw_word[1:0] == 2'b11 && insn_class != CLS_INVALID;

	// An invalid item carries no class, operation or immediate.
	`ASSERT_ON_OUT(a_invalid_zeroed, !is_valid |-> decode_zero, "invalid item has decode fields")

	// Register fields always match the word they came from.
	`ASSERT_ON_OUT(a_fields_match_word, fields_match, "register fields do not match raw word")

	// A valid decode needs a 32-bit encoding and a nonzero class.
	`ASSERT_ON_OUT(a_valid_encoding, is_valid |-> encoding_ok, "valid item with bad encoding")

	// A stalled result item stays presented with its raw word unchanged.
	`ASSERT_CLK(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(raw_word), "stall")

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.is_valid      (is_valid),
	.insn_class    (insn_class),
	.alu_operation (alu_operation),
	.immediate     (immediate),
	.dest_reg      (dest_reg),
	.src1_reg      (src1_reg),
	.src2_reg      (src2_reg),
	.func3_field   (func3_field),
	.raw_word      (raw_word)
);

// ----- test/tb_rv32i_instruction_decoder.sv -----
// Self-checking testbench for the RV32I instruction decoder.
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder;
	import rvdec_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int MAX_CYCLES = 200_000;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_PER_PHASE = 335;
	localparam int HOLD_CYCLES = 40;

	// One decoded instruction as it leaves the block.
	typedef struct packed {
		logic        valid;
		insn_class_t cls;
		alu_op_t     alu;
		logic [31:0] imm;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [2:0]  f3;
		logic [31:0] pc;
		logic [31:0] word;
	} decoded_t;

	// Directed row: when pinned, the valid flag, class, ALU operation and immediate are typed in.
	typedef struct packed {
		logic [31:0] word;
		logic [31:0] pc;
		logic        pinned;
		logic        valid;
		insn_class_t cls;
		alu_op_t     alu;
		logic [31:0] imm;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [31:0]        instr_word = '0;
	logic [31:0]        fetch_pc = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               is_valid;
	logic [3:0]         insn_class;
	logic [3:0]         alu_operation;
	logic signed [31:0] immediate;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic [2:0]         func3_field;
	logic [31:0]        pc_out;
	logic [31:0]        raw_word;

	decoded_t    pending_decodes[$];
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned invalid_seen = 0;
	int unsigned fail_count = 0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000},
		'{32'hFFFF_FFFE, 32'h0000_0004, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000},
		'{32'hFFFF_F037, 32'hFFFF_FFFC, 1'b1, 1'b1, CLS_LUI, ALU_ADD, 32'hFFFF_F000},
		'{32'h0000_1017, 32'h8000_0000, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h8000_006F, 32'h7FFF_FFFF, 1'b1, 1'b1, CLS_JAL, ALU_ADD, 32'hFFF0_0000},
		'{32'hFFF0_0067, 32'h0000_1000, 1'b1, 1'b1, CLS_JALR, ALU_ADD, 32'hFFFF_FFFF},
		'{32'hFE00_0FE3, 32'h0000_2000, 1'b1, 1'b1, CLS_BRANCH, ALU_ADD, 32'hFFFF_FFFE},
		'{32'h7FF0_A283, 32'h5555_5555, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'hFE11_2FA3, 32'hAAAA_AAAA, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h8000_0013, 32'h0000_0010, 1'b1, 1'b1, CLS_ALU_IMM, ALU_ADD, 32'hFFFF_F800},
		'{32'h01F0_1013, 32'h0000_0014, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h41F0_5013, 32'h0000_0018, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'hFE00_5093, 32'h0000_001C, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'hFFF0_7F13, 32'h0000_0020, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h0000_0033, 32'h0000_0024, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h4000_0033, 32'h0000_0028, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h4000_5033, 32'h0000_002C, 1'b0, 1'b0, CLS_INVALID, ALU_ADD, 32'h0},
		'{32'h4000_1033, 32'h0000_0030, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000},
		'{32'h0200_0033, 32'h0000_0034, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000},
		'{32'hFFFF_FF8F, 32'h0000_0038, 1'b1, 1'b1, CLS_FENCE, ALU_ADD, 32'h0000_0000},
		'{32'h0000_0073, 32'h0000_003C, 1'b1, 1'b1, CLS_ECALL, ALU_ADD, 32'h0000_0000},
		'{32'h0010_0073, 32'h0000_0040, 1'b1, 1'b1, CLS_EBREAK, ALU_ADD, 32'h0000_0000},
		'{32'h3000_1073, 32'h0000_0044, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000},
		'{32'h0020_0073, 32'h0000_0048, 1'b1, 1'b0, CLS_INVALID, ALU_ADD, 32'h0000_0000}
	};

	rv32i_instruction_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.instr_word    (instr_word),
		.fetch_pc      (fetch_pc),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_valid      (is_valid),
		.insn_class    (insn_class),
		.alu_operation (alu_operation),
		.immediate     (immediate),
		.dest_reg      (dest_reg),
		.src1_reg      (src1_reg),
		.src2_reg      (src2_reg),
		.func3_field   (func3_field),
		.pc_out        (pc_out),
		.raw_word      (raw_word)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic alu_op_t alu_for_funct3(input logic [2:0] f3);
		case (f3)
			3'd0: return ALU_ADD;
			3'd1: return ALU_SLL;
			3'd2: return ALU_SLT;
			3'd3: return ALU_SLTU;
			3'd4: return ALU_XOR;
			3'd5: return ALU_SRL;
			3'd6: return ALU_OR;
			default: return ALU_AND;
		endcase
	endfunction

	function automatic decoded_t predict_decode(input logic [31:0] w, input logic [31:0] pc);
		decoded_t d;
		logic [2:0] f3;
		logic [6:0] f7;
		f3 = w[14:12];
		f7 = w[31:25];
		d.valid = 1'b1;
		d.cls = CLS_INVALID;
		d.alu = ALU_ADD;
		d.imm = '0;
		d.rd = w[11:7];
		d.rs1 = w[19:15];
		d.rs2 = w[24:20];
		d.f3 = f3;
		d.pc = pc;
		d.word = w;
		if (w[1:0] != 2'b11) begin
			d.valid = 1'b0;
		end else begin
			case (w[6:0])
				OPC_LUI: begin
					d.cls = CLS_LUI;
					d.imm = {w[31:12], 12'h000};
				end
				OPC_AUIPC: begin
					d.cls = CLS_AUIPC;
					d.imm = {w[31:12], 12'h000};
				end
				OPC_JAL: begin
					d.cls = CLS_JAL;
					d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
				end
				OPC_JALR: begin
					d.cls = CLS_JALR;
					d.imm = {{20{w[31]}}, w[31:20]};
				end
				OPC_BRANCH: begin
					d.cls = CLS_BRANCH;
					d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				end
				OPC_LOAD: begin
					d.cls = CLS_LOAD;
					d.imm = {{20{w[31]}}, w[31:20]};
				end
				OPC_STORE: begin
					d.cls = CLS_STORE;
					d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				end
				OPC_OP_IMM: begin
					// Immediate shifts ignore funct7 apart from the bit that picks sra.
					if (f3 == F3_SLL || f3 == F3_SRL) begin
						d.cls = CLS_SHIFT_IMM;
						d.imm = {27'd0, w[24:20]};
						if (f3 == F3_SLL)
							d.alu = ALU_SLL;
						else
							d.alu = f7[5] ? ALU_SRA : ALU_SRL;
					end else begin
						d.cls = CLS_ALU_IMM;
						d.imm = {{20{w[31]}}, w[31:20]};
						d.alu = alu_for_funct3(f3);
					end
				end
				OPC_OP: begin
					d.cls = CLS_ALU_REG;
					if (f7 == F7_ALT && f3 == F3_ADD)
						d.alu = ALU_SUB;
					else if (f7 == F7_ALT && f3 == F3_SRL)
						d.alu = ALU_SRA;
					else if (f7 == F7_BASE)
						d.alu = alu_for_funct3(f3);
					else
						d.valid = 1'b0;
				end
				OPC_MISC_MEM: begin
					d.cls = CLS_FENCE;
				end
				OPC_SYSTEM: begin
					d.valid = 1'b0;
					if (f3 == '0 && w[11:7] == '0 && w[19:15] == '0) begin
						if (w[31:20] == SYS_ECALL) begin
							d.cls = CLS_ECALL;
							d.valid = 1'b1;
						end else if (w[31:20] == SYS_EBREAK) begin
							d.cls = CLS_EBREAK;
							d.valid = 1'b1;
						end
					end
				end
				default: d.valid = 1'b0;
			endcase
		end
		if (!d.valid) begin
			d.cls = CLS_INVALID;
			d.alu = ALU_ADD;
			d.imm = '0;
		end
		return d;
	endfunction

	// Mostly well-formed words with random content; the rest is noise or has bad low bits.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int unsigned pick;
		int unsigned bit_idx;
		w = $urandom();
		pick = $urandom_range(99);
		if (pick < 12)
			return w;
		case ($urandom_range(10))
			0: w[6:0] = OPC_LUI;
			1: w[6:0] = OPC_AUIPC;
			2: w[6:0] = OPC_JAL;
			3: w[6:0] = OPC_JALR;
			4: w[6:0] = OPC_BRANCH;
			5: w[6:0] = OPC_LOAD;
			6: w[6:0] = OPC_STORE;
			7: begin
				w[6:0] = OPC_OP_IMM;
				if ($urandom_range(1) == 1) begin
					w[14:12] = $urandom_range(1) ? F3_SLL : F3_SRL;
					if ($urandom_range(3) != 0)
						w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
				end
			end
			8: begin
				w[6:0] = OPC_OP;
				case ($urandom_range(9))
					0: ;
					1, 2, 3: w[31:25] = F7_ALT;
					default: w[31:25] = F7_BASE;
				endcase
			end
			9: w[6:0] = OPC_MISC_MEM;
			default: begin
				w[6:0] = OPC_SYSTEM;
				if ($urandom_range(3) != 0) begin
					w[31:7] = '0;
					w[31:20] = $urandom_range(1) ? SYS_EBREAK : SYS_ECALL;
					// A quarter of these get one bit broken somewhere above the opcode.
					if ($urandom_range(3) == 0) begin
						bit_idx = $urandom_range(31, 7);
						w[bit_idx] = ~w[bit_idx];
					end
				end
			end
		endcase
		if (pick < 20)
			w[1:0] = 2'($urandom_range(2));
		return w;
	endfunction

	task automatic send_item(input logic [31:0] w, input logic [31:0] pc, input decoded_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		instr_word <= w;
		fetch_pc <= pc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_decodes.push_back(want);
		items_sent++;
	endtask

	// Output side: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.valid = is_valid;
			got.cls = insn_class_t'(insn_class);
			got.alu = alu_op_t'(alu_operation);
			got.imm = immediate;
			got.rd = dest_reg;
			got.rs1 = src1_reg;
			got.rs2 = src2_reg;
			got.f3 = func3_field;
			got.pc = pc_out;
			got.word = raw_word;
			results_checked++;
			if (!got.valid)
				invalid_seen++;
			if (pending_decodes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR: result for word %h pc %h with no item pending",
						got.word, got.pc);
			end else begin
				want = pending_decodes.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("ERROR: word %h: expected v%0d cls %0d alu %0d imm %h",
							want.word, want.valid, want.cls, want.alu, want.imm);
						$display("       rd %0d rs1 %0d rs2 %0d f3 %0d pc %h word %h",
							want.rd, want.rs1, want.rs2, want.f3, want.pc, want.word);
						$display("       got v%0d cls %0d alu %0d imm %h",
							got.valid, got.cls, got.alu, got.imm);
						$display("       rd %0d rs1 %0d rs2 %0d f3 %0d pc %h word %h",
							got.rd, got.rs1, got.rs2, got.f3, got.pc, got.word);
					end
				end
			end
		end
	end

	initial begin
		#(CLK_HALF * 2 * MAX_CYCLES);
		$display("timeout with %0d results still pending", pending_decodes.size());
		$display("rv32i_instruction_decoder regression: fail");
		$finish;
	end

	initial begin
		logic [31:0] w;
		logic [31:0] pc;
		decoded_t want;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			want = predict_decode(directed_rows[i].word, directed_rows[i].pc);
			if (directed_rows[i].pinned) begin
				want.valid = directed_rows[i].valid;
				want.cls = directed_rows[i].cls;
				want.alu = directed_rows[i].alu;
				want.imm = directed_rows[i].imm;
			end
			send_item(directed_rows[i].word, directed_rows[i].pc, want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 63; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 63; end
				default: begin send_idle_pct = 34; stall_pct = 34; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Hold the output off while items keep coming, so the input side backs up.
				if (ph == 0 && n == 100)
					hold_request = 1'b1;
				w = random_word();
				pc = $urandom();
				send_item(w, pc, predict_decode(w, pc));
			end
		end
		in_valid <= 1'b0;

		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d items (%0d directed, %0d random) under four handshake mixes",
			items_sent, DIRECTED_ROWS, 4 * RANDOM_PER_PHASE);
		$display("and one long output hold; %0d results checked, %0d invalid encodings.",
			results_checked, invalid_seen);
		if (fail_count == 0 && pending_decodes.size() == 0) begin
			$display("rv32i_instruction_decoder regression: pass");
		end else begin
			$display("%0d failures", fail_count);
			$display("rv32i_instruction_decoder regression: fail");
		end
		$finish;
	end

endmodule
